// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds from the next cycle on
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Transaction types, constants and helpers of the HSV to RGB converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // input transaction: one HSV color
  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // output transaction: one RGB color
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // 60-degree hue sectors, named by the channel ordering they produce
  typedef enum logic [2:0] {
    SEC_RED_RISE_GREEN  = 3'd0,
    SEC_GREEN_FALL_RED  = 3'd1,
    SEC_GREEN_RISE_BLUE = 3'd2,
    SEC_BLUE_FALL_GREEN = 3'd3,
    SEC_BLUE_RISE_RED   = 3'd4,
    SEC_RED_FALL_BLUE   = 3'd5
  } sector_t;

  localparam int unsigned HUE_W     = 9;
  localparam int unsigned PROD_W    = 17;   // s * t, up to 255 * 360
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned RECIP_SH  = 26;
  // floor(2^26 / 360): estimate is exact or one low over the product range
  localparam logic [RECIP_W-1:0] RECIP_360 = 18'd186413;
  localparam logic [PROD_W-1:0]  DEG_360   = 17'd360;
  localparam logic [8:0]         SECTOR_DEG = 9'd60;
  localparam logic [8:0]         STEP_MUL   = 9'd6;
  localparam logic [8:0]         FULL_TURN  = 9'd360;
  localparam logic [7:0]         FULL_LEVEL = 8'd255;

  // floor(y / 255), exact while the quotient fits 8 bits (y up to 255 * 256 - 1)
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] acc;
    acc = {1'b0, y} + 17'(y[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsv_to_rgb_integer_core.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_integer_core
// Six-stage pipelined integer HSV to RGB color converter.
// ---------------------------------------------------------------------------
//
//  channel | ports                    | transaction
//  --------+--------------------------+-------------------------------
//  input   | start, busy, pixel       | start & !busy, one HSV color
//  output  | done, color              | done strobe, one RGB color
//
// One color enters every cycle; busy is always low.
// Stages in order: sector split, hue products, reciprocal multiply
// for the /360, quotient correction, brightness products, /255 and select.
// Synchronous reset clears only the stage valid bits.
// The receiver cannot stall; results appear for one cycle with done.
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb_integer_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire hsv2rgb_pkg::hsv_t  pixel,
  output logic                    done,
  output hsv2rgb_pkg::rgb_t       color
);

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;

  // stage 1 payload
  hsv2rgb_pkg::sector_t sec1;
  logic [8:0]           t1, tc1;
  logic [7:0]           s1, b1;
  logic [15:0]          lop1;
  logic                 grey1;

  // stage 2 payload
  hsv2rgb_pkg::sector_t sec2;
  logic [7:0]           b2, lo2;
  logic [16:0]          fp2, rp2;
  logic                 grey2;

  // stage 3 payload
  hsv2rgb_pkg::sector_t sec3;
  logic [7:0]           b3, lo3, qf3, qr3;
  logic [16:0]          fp3, rp3;
  logic                 grey3;

  // stage 4 payload
  hsv2rgb_pkg::sector_t sec4;
  logic [7:0]           b4, lo4, cutf4, cutr4;
  logic                 grey4;

  // stage 5 payload
  hsv2rgb_pkg::sector_t sec5;
  logic [7:0]           b5, lo5;
  logic [15:0]          lvf5, lvr5;
  logic                 grey5;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 0: hue / 60 by threshold count, offset within sector
  logic [3:0]           q60;
  logic [8:0]           hmod;
  logic [8:0]           t0;
  hsv2rgb_pkg::sector_t sec0;

  always_comb begin
    q60 = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (pixel.hue >= 9'(k * 60)) q60 = q60 + 4'd1;
    end
    hmod = pixel.hue - 9'(q60) * hsv2rgb_pkg::SECTOR_DEG;
    t0   = hmod * hsv2rgb_pkg::STEP_MUL;
    if (q60 > 4'd5) sec0 = hsv2rgb_pkg::SEC_RED_FALL_BLUE;
    else            sec0 = hsv2rgb_pkg::sector_t'(q60[2:0]);
  end

  always_ff @(posedge clk) begin
    sec1  <= sec0;
    t1    <= t0;
    tc1   <= hsv2rgb_pkg::FULL_TURN - t0;
    s1    <= pixel.saturation;
    b1    <= pixel.brightness;
    lop1  <= 16'(pixel.brightness) * 16'(hsv2rgb_pkg::FULL_LEVEL - pixel.saturation);
    grey1 <= (pixel.saturation == 8'd0);
  end

  // stage 1: saturation times sector position, minimum level
  always_ff @(posedge clk) begin
    sec2  <= sec1;
    b2    <= b1;
    lo2   <= hsv2rgb_pkg::div255(lop1);
    fp2   <= 17'(s1) * 17'(t1);
    rp2   <= 17'(s1) * 17'(tc1);
    grey2 <= grey1;
  end

  // stage 2: reciprocal multiply estimates the / 360
  logic [34:0] fe2, re2;
  assign fe2 = 35'(fp2) * 35'(hsv2rgb_pkg::RECIP_360);
  assign re2 = 35'(rp2) * 35'(hsv2rgb_pkg::RECIP_360);

  always_ff @(posedge clk) begin
    sec3  <= sec2;
    b3    <= b2;
    lo3   <= lo2;
    fp3   <= fp2;
    rp3   <= rp2;
    qf3   <= fe2[hsv2rgb_pkg::RECIP_SH +: 8];
    qr3   <= re2[hsv2rgb_pkg::RECIP_SH +: 8];
    grey3 <= grey2;
  end

  // stage 3: bump the estimate when the remainder reaches 360
  logic [16:0] remf3, remr3;
  assign remf3 = fp3 - 17'(qf3) * hsv2rgb_pkg::DEG_360;
  assign remr3 = rp3 - 17'(qr3) * hsv2rgb_pkg::DEG_360;

  always_ff @(posedge clk) begin
    sec4  <= sec3;
    b4    <= b3;
    lo4   <= lo3;
    cutf4 <= qf3 + 8'(remf3 >= hsv2rgb_pkg::DEG_360);
    cutr4 <= qr3 + 8'(remr3 >= hsv2rgb_pkg::DEG_360);
    grey4 <= grey3;
  end

  // stage 4: brightness times the remaining fraction
  always_ff @(posedge clk) begin
    sec5  <= sec4;
    b5    <= b4;
    lo5   <= lo4;
    lvf5  <= 16'(b4) * 16'(hsv2rgb_pkg::FULL_LEVEL - cutf4);
    lvr5  <= 16'(b4) * 16'(hsv2rgb_pkg::FULL_LEVEL - cutr4);
    grey5 <= grey4;
  end

  // stage 5: / 255 and sector routing into the output register
  logic [7:0]        fall5, rise5;
  hsv2rgb_pkg::rgb_t rgb5;

  always_comb begin
    fall5 = hsv2rgb_pkg::div255(lvf5);
    rise5 = hsv2rgb_pkg::div255(lvr5);
    if (grey5) begin
      rgb5 = '{red: b5, green: b5, blue: b5};
    end else begin
      unique case (sec5)
        hsv2rgb_pkg::SEC_RED_RISE_GREEN:  rgb5 = '{red: b5,    green: rise5, blue: lo5};
        hsv2rgb_pkg::SEC_GREEN_FALL_RED:  rgb5 = '{red: fall5, green: b5,    blue: lo5};
        hsv2rgb_pkg::SEC_GREEN_RISE_BLUE: rgb5 = '{red: lo5,   green: b5,    blue: rise5};
        hsv2rgb_pkg::SEC_BLUE_FALL_GREEN: rgb5 = '{red: lo5,   green: fall5, blue: b5};
        hsv2rgb_pkg::SEC_BLUE_RISE_RED:   rgb5 = '{red: rise5, green: lo5,   blue: b5};
        default:                          rgb5 = '{red: b5,    green: lo5,   blue: fall5};
      endcase
    end
  end

  logic [7:0] b6;

  always_ff @(posedge clk) begin
    color <= rgb5;
    b6    <= b5;
  end

  assign done = v6;

  // checks
  `ASSERT_NEXT(a_latency, clk, rst, accept, ##5 done)
  `ASSERT_IMPLIES(a_quot_est, clk, rst, v3, (remf3 < 17'd720) && (remr3 < 17'd720))
  `ASSERT_NEXT(a_grey_out, clk, rst, v5 && grey5, (color.red == color.green) && (color.green == color.blue))
  `ASSERT_IMPLIES(a_brightness_kept, clk, rst, done, (color.red == b6) || (color.green == b6) || (color.blue == b6))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined integer HSV to RGB converter. Colors
// are sent as directed corner cases (grey, every sector boundary, hues past
// 359, level extremes) and then as random colors under several
// sender-idle phases. Each accepted transaction is predicted in the bench.
// Every done strobe is checked field by field against the oldest
// prediction.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FULL        = 255;
  localparam int unsigned TURN        = 360;
  localparam int unsigned SECTOR_SPAN = 60;
  localparam int unsigned STEP        = 6;
  localparam int unsigned LAST_SECTOR = 5;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    hsv2rgb_pkg::hsv_t src;
    hsv2rgb_pkg::rgb_t want;
  } pending_color_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  hsv2rgb_pkg::hsv_t pixel;
  logic              done;
  hsv2rgb_pkg::rgb_t color;

  pending_color_t pending_colors[$];
  int unsigned    mismatch_count;
  int unsigned    idle_pct;
  longint unsigned cycle_count;

  hsv_to_rgb_integer_core DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .pixel (pixel),
    .done  (done),
    .color (color)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one brightness level: v scaled by (255 - cut) / 255, truncating
  function automatic int unsigned scale_level(int unsigned v, int unsigned cut);
    return (v * (FULL - cut)) / FULL;
  endfunction

  // expected RGB for one HSV color
  function automatic hsv2rgb_pkg::rgb_t hsv_to_rgb_expect(hsv2rgb_pkg::hsv_t c);
    int unsigned          h;
    int unsigned          s;
    int unsigned          v;
    int unsigned          t;
    int unsigned          floor_lvl;
    int unsigned          fall_lvl;
    int unsigned          rise_lvl;
    hsv2rgb_pkg::sector_t sec;
    hsv2rgb_pkg::rgb_t    res;
    h = 32'(c.hue);
    s = 32'(c.saturation);
    v = 32'(c.brightness);
    if (s == 0) begin
      res.red   = 8'(v);
      res.green = 8'(v);
      res.blue  = 8'(v);
      return res;
    end
    t         = STEP * (h % SECTOR_SPAN);
    floor_lvl = scale_level(v, s);
    fall_lvl  = scale_level(v, (s * t) / TURN);
    rise_lvl  = scale_level(v, (s * (TURN - t)) / TURN);
    // hues of 300 and above all land in the last sector
    sec = (h / SECTOR_SPAN > LAST_SECTOR) ? hsv2rgb_pkg::SEC_RED_FALL_BLUE :
                                            hsv2rgb_pkg::sector_t'(h / SECTOR_SPAN);
    case (sec)
      hsv2rgb_pkg::SEC_RED_RISE_GREEN: begin
        res = '{8'(v), 8'(rise_lvl), 8'(floor_lvl)};
      end
      hsv2rgb_pkg::SEC_GREEN_FALL_RED: begin
        res = '{8'(fall_lvl), 8'(v), 8'(floor_lvl)};
      end
      hsv2rgb_pkg::SEC_GREEN_RISE_BLUE: begin
        res = '{8'(floor_lvl), 8'(v), 8'(rise_lvl)};
      end
      hsv2rgb_pkg::SEC_BLUE_FALL_GREEN: begin
        res = '{8'(floor_lvl), 8'(fall_lvl), 8'(v)};
      end
      hsv2rgb_pkg::SEC_BLUE_RISE_RED: begin
        res = '{8'(rise_lvl), 8'(floor_lvl), 8'(v)};
      end
      default: begin
        res = '{8'(v), 8'(floor_lvl), 8'(fall_lvl)};
      end
    endcase
    return res;
  endfunction

  // send one color; called just after a falling edge, returns just after a falling edge once the color is accepted
  task automatic send_color(hsv2rgb_pkg::hsv_t c);
    pending_color_t entry;
    // random sender gaps, with scrambled payload while start is low
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      pixel = hsv2rgb_pkg::hsv_t'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    pixel = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    entry.src  = c;
    entry.want = hsv_to_rgb_expect(c);
    pending_colors.push_back(entry);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic hsv2rgb_pkg::hsv_t make_hsv(int unsigned h, int unsigned s,
                                                 int unsigned v);
    hsv2rgb_pkg::hsv_t c;
    c.hue        = 9'(h);
    c.saturation = 8'(s);
    c.brightness = 8'(v);
    return c;
  endfunction

  // zero saturation gives grey at any hue
  task automatic test_grey();
    send_color(make_hsv(0, 0, 0));
    send_color(make_hsv(511, 0, 255));
    send_color(make_hsv(123, 0, 77));
    send_color(make_hsv(360, 0, 170));
  endtask

  // every sector boundary, hues past a full turn, level extremes
  task automatic test_sector_edges();
    send_color(make_hsv(0, 255, 255));
    send_color(make_hsv(59, 255, 255));
    send_color(make_hsv(60, 255, 255));
    send_color(make_hsv(119, 200, 255));
    send_color(make_hsv(120, 255, 255));
    send_color(make_hsv(179, 1, 255));
    send_color(make_hsv(180, 255, 128));
    send_color(make_hsv(240, 255, 255));
    send_color(make_hsv(299, 128, 200));
    send_color(make_hsv(300, 255, 255));
    send_color(make_hsv(359, 255, 255));
    send_color(make_hsv(360, 255, 255));
    send_color(make_hsv(419, 128, 200));
    send_color(make_hsv(420, 1, 255));
    send_color(make_hsv(480, 255, 1));
    send_color(make_hsv(511, 255, 255));
    send_color(make_hsv(511, 1, 0));
    send_color(make_hsv(30, 255, 0));
    send_color(make_hsv(200, 170, 85));
  endtask

  // random colors, biased toward saturation and brightness extremes
  task automatic test_random(int unsigned count);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    for (int unsigned i = 0; i < count; i++) begin
      h = $urandom_range(511);
      case ($urandom_range(7))
        0:       s = 0;
        1:       s = FULL;
        default: s = $urandom_range(FULL);
      endcase
      case ($urandom_range(7))
        0:       v = 0;
        1:       v = FULL;
        default: v = $urandom_range(FULL);
      endcase
      send_color(make_hsv(h, s, v));
    end
  endtask

  // check each result against the oldest prediction
  always @(posedge clk) begin
    pending_color_t entry;
    if (!rst && done) begin
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result r=%0d g=%0d b=%0d",
                   color.red, color.green, color.blue);
      end else begin
        entry = pending_colors.pop_front();
        if (color.red !== entry.want.red || color.green !== entry.want.green ||
            color.blue !== entry.want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"ERROR: h=%0d s=%0d v=%0d expected r=%0d g=%0d b=%0d",
                      " got r=%0d g=%0d b=%0d"},
                     entry.src.hue, entry.src.saturation, entry.src.brightness,
                     entry.want.red, entry.want.green, entry.want.blue,
                     color.red, color.green, color.blue);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    pixel          = '0;
    mismatch_count = 0;
    idle_pct       = 0;
    cycle_count    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_grey();
    test_sector_edges();
    // back-to-back, heavy sender gaps, light sender gaps
    test_random(RANDOM_ITEMS / 4);
    idle_pct = 73;
    test_random(RANDOM_ITEMS / 4);
    idle_pct = 0;
    test_random(RANDOM_ITEMS / 8);
    idle_pct = 30;
    test_random(RANDOM_ITEMS / 4);
    idle_pct = 0;
    test_random(RANDOM_ITEMS / 8);

    // drain the pipeline
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_integer_core.sv
tb/tb_top.sv
